// ----- src/zrs_pkg.sv -----
// Package for the Zipf rank sampler: payload structs, action codes and
// generator constants. No dependencies.
package zrs_pkg;

  localparam int MAX_RANKS = 1024;
  localparam int ADDR_W    = $clog2(MAX_RANKS);
  localparam int RANK_W    = 11;
  localparam int VAL_W     = 31;

  localparam logic [1:0] ACT_DRAW    = 2'd0;
  localparam logic [1:0] ACT_LOAD    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [0:0] REG_N_ACTIVE = 1'd0;
  localparam logic [0:0] REG_SEED     = 1'd1;

  localparam logic [14:0]      LCG_A   = 15'd16807;
  localparam logic [VAL_W-1:0] LCG_M   = 31'h7FFF_FFFF;
  localparam logic [RANK_W-1:0] N_MAX  = RANK_W'(MAX_RANKS);

  typedef struct packed {
    logic [1:0]        action;
    logic [RANK_W-1:0] rank_index;
    logic [VAL_W-1:0]  weight;
  } in_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [VAL_W-1:0]  uniform_value;
    logic              no_rank;
  } out_t;

endpackage

// ----- src/zipf_rank_sampler.sv -----
// Zipf rank sampler: a draw runs MUL, RED, WALK (k ranks) and DONE, where k is
// 1..n_active clamped to 1..1024; one shared add/saturate/compare unit walks
// the weight RAM one rank a cycle. The input stalls until a draw is done; loads
// and restarts complete in idle. Output register frees the input side.
// Synchronous active-low reset: generator = 1, n_active = 1024, seed = 1.
// Weight RAM is not cleared by reset. Depends on zrs_pkg and zrs_ram.
module zipf_rank_sampler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  zrs_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output zrs_pkg::out_t      out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_wdata
);
  import zrs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_RED  = 5'b00100,
    ST_WALK = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [RANK_W-1:0]   n_active_r, n_active_nxt;
  logic [VAL_W-1:0]    seed_r, seed_nxt;
  logic [VAL_W-1:0]    gen_r, gen_nxt;
  logic [45:0]         prod_r, prod_nxt;
  logic [RANK_W-1:0]   n_r, n_nxt;
  logic [RANK_W-1:0]   cnt_r, cnt_nxt;
  logic [VAL_W-1:0]    sum_r, sum_nxt;
  logic [RANK_W-1:0]   rank_r, rank_nxt;
  logic                miss_r, miss_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  logic                in_acc;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [VAL_W-1:0]    ram_rdata;
  logic [RANK_W-1:0]   load_m1;
  logic [31:0]         red_sum;
  logic [31:0]         walk_add;
  logic [VAL_W-1:0]    walk_sat;
  logic                walk_hit;
  logic                out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Weight load: ranks outside 1..MAX_RANKS are dropped.
  assign load_m1   = in_data.rank_index - RANK_W'(1);
  assign ram_we    = in_acc && (in_data.action == ACT_LOAD) &&
                     (in_data.rank_index != '0) && (in_data.rank_index <= N_MAX);
  assign ram_waddr = load_m1[ADDR_W-1:0];
  assign ram_raddr = (state_r == ST_RED) ? '0 : cnt_r[ADDR_W-1:0];

  zrs_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_RANKS)
  ) u_weights (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_data.weight),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Mod 2^31-1 by folding the high bits onto the low bits.
  assign red_sum = {1'b0, prod_r[30:0]} + {17'd0, prod_r[45:31]};

  // Shared walk unit: saturating add and compare against the draw value.
  assign walk_add = {1'b0, sum_r} + {1'b0, ram_rdata};
  assign walk_sat = walk_add[31] ? LCG_M : walk_add[30:0];
  assign walk_hit = (walk_sat >= gen_r);

  always_comb begin
    state_nxt     = state_r;
    n_active_nxt  = n_active_r;
    seed_nxt      = seed_r;
    gen_nxt       = gen_r;
    prod_nxt      = prod_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    rank_nxt      = rank_r;
    miss_nxt      = miss_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      if (cfg_index == REG_N_ACTIVE) begin
        n_active_nxt = cfg_wdata[RANK_W-1:0];
      end else begin
        seed_nxt = cfg_wdata;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.action == ACT_DRAW) begin
            if (n_active_r == '0) begin
              n_nxt = RANK_W'(1);
            end else if (n_active_r > N_MAX) begin
              n_nxt = N_MAX;
            end else begin
              n_nxt = n_active_r;
            end
            state_nxt = ST_MUL;
          end else if (in_data.action == ACT_RESTART) begin
            gen_nxt = (seed_r == '0 || seed_r == LCG_M) ? VAL_W'(1) : seed_r;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = {15'd0, gen_r} * {31'd0, LCG_A};
        state_nxt = ST_RED;
      end
      ST_RED: begin
        gen_nxt   = (red_sum >= {1'b0, LCG_M}) ? VAL_W'(red_sum - {1'b0, LCG_M})
                                               : red_sum[30:0];
        cnt_nxt   = RANK_W'(1);
        sum_nxt   = '0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        sum_nxt = walk_sat;
        if (walk_hit) begin
          rank_nxt  = cnt_r;
          miss_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end else if (cnt_r == n_r) begin
          rank_nxt  = n_r;
          miss_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + RANK_W'(1);
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.rank          = rank_r;
          out_data_nxt.uniform_value = gen_r;
          out_data_nxt.no_rank       = miss_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_active_r  <= N_MAX;
      seed_r      <= VAL_W'(1);
      gen_r       <= VAL_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_active_r  <= n_active_nxt;
      seed_r      <= seed_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    n_r        <= n_nxt;
    cnt_r      <= cnt_nxt;
    sum_r      <= sum_nxt;
    rank_r     <= rank_nxt;
    miss_r     <= miss_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Generator never reaches a lock-up value.
  a_gen_range: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_r != '0) && (gen_r != LCG_M))
    else $error("generator left its cycle");

  // Walk counter stays within the effective rank count.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (cnt_r != '0) && (cnt_r <= n_r) && (n_r <= N_MAX))
    else $error("walk counter out of range");

  // A missed walk reports the last rank walked.
  a_miss_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && miss_r) |-> (rank_r == n_r))
    else $error("no_rank result with wrong rank");

  // A finished draw is published through the output register once that register is free, and the FSM returns to idle.
  a_publish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> out_valid && (state_r == ST_IDLE))
    else $error("finished draw not published");

endmodule

// ----- src/zrs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module zrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- test/zipf_rank_sampler_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for zipf_rank_sampler. It drives draw, load and restart
// transactions and checks every rank against a mirror of the weight table and generator.
// Depends on zrs_pkg and the zipf_rank_sampler RTL.
module zipf_rank_sampler_tb;
  import zrs_pkg::*;

  localparam int LIMIT_CYCLES = 2_500_000;
  localparam int RANDOM_ITEMS = 580;
  localparam int SETTLE_CYCLES = 16;
  localparam int ZIPF_SCALE = 285_970_000;  // (2^31-1) / H(1024), a bit under
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [31:0] SCHRAGE_Q = 32'd127773;
  localparam logic [31:0] SCHRAGE_R = 32'd2836;
  localparam logic [30:0] SEED_TOP = 31'h7FFF_FFFE;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_N_ACTIVE;
  logic [30:0] cfg_wdata = '0;

  zipf_rank_sampler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // mirror of the sampler
  logic [30:0] gen_state = 31'd1;
  logic [30:0] seed_reg = 31'd1;
  logic [10:0] n_active_reg = 11'd1024;
  logic [30:0] weight_mirror [1:MAX_RANKS];
  out_t        expected_ranks [$];

  int  mismatches = 0;
  int  ranks_checked = 0;
  int  misses_seen = 0;
  int  draws_sent = 0;
  int  loads_applied = 0;
  int  restarts_sent = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  bit  send_idle_en = 1'b1;
  bit  recv_idle_en = 1'b1;
  int  hold_request = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  out_t want_rank;

  function automatic logic [30:0] next_uniform(input logic [30:0] x);
    logic [31:0] hi, lo, t1, t2;
    hi = 32'(x) / SCHRAGE_Q;
    lo = 32'(x) % SCHRAGE_Q;
    t1 = 32'(LCG_A) * lo;
    t2 = SCHRAGE_R * hi;
    if (t1 > t2)
      return 31'(t1 - t2);
    return 31'(32'(LCG_M) - (t2 - t1));
  endfunction

  function automatic int active_ranks(input logic [10:0] n);
    if (n == 11'd0)
      return 1;
    if (n > N_MAX)
      return MAX_RANKS;
    return int'(n);
  endfunction

  // advance the generator, then walk the inverse CDF with a saturating sum
  function automatic out_t draw_rank();
    int          n;
    logic [31:0] sum;
    out_t        r;
    n = active_ranks(n_active_reg);
    gen_state = next_uniform(gen_state);
    r.rank = 11'(n);
    r.uniform_value = gen_state;
    r.no_rank = 1'b1;
    sum = '0;
    for (int i = 1; i <= n; i++) begin
      sum = sum + 32'(weight_mirror[i]);
      if (sum > 32'(LCG_M))
        sum = 32'(LCG_M);
      if (sum >= 32'(gen_state)) begin
        r.rank = 11'(i);
        r.no_rank = 1'b0;
        break;
      end
    end
    return r;
  endfunction

  function automatic void track_transaction(input in_t item);
    case (item.action)
      ACT_DRAW: begin
        expected_ranks.push_back(draw_rank());
        draws_sent++;
      end
      ACT_LOAD: begin
        if (item.rank_index >= 11'd1 && item.rank_index <= N_MAX) begin
          weight_mirror[item.rank_index] = item.weight;
          loads_applied++;
        end
      end
      ACT_RESTART: begin
        gen_state = (seed_reg == 31'd0 || seed_reg == LCG_M) ? 31'd1 : seed_reg;
        restarts_sent++;
      end
      default: ;
    endcase
  endfunction

  function automatic bit is_ignored(input in_t item);
    return item.action == ACT_UNUSED ||
           (item.action == ACT_LOAD && (item.rank_index == 11'd0 || item.rank_index > N_MAX));
  endfunction

  function automatic logic [30:0] zipf_weight(input int r);
    return 31'(ZIPF_SCALE / r);
  endfunction

  function automatic in_t make_item(input logic [1:0] action, input int idx,
                                    input logic [30:0] weight);
    in_t it;
    it.action = action;
    it.rank_index = 11'(idx);
    it.weight = weight;
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic send_item(input in_t item);
    int gap;
    gap = send_idle_en ? $urandom_range(13, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (in_stall);
    track_transaction(item);
  endtask

  task automatic send(input logic [1:0] action, input int idx, input logic [30:0] weight);
    send_item(make_item(action, idx, weight));
  endtask

  // drain every expected rank, then let trailing loads and restarts retire
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [30:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_N_ACTIVE)
      n_active_reg = value[10:0];
    else
      seed_reg = value;
  endtask

  // receiver: long hold-off on request, otherwise a random wait per result
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ranks.size() == 0) begin
        report_mismatch("unexpected result, rank", 32'(out_data.rank), 32'd0);
      end else begin
        want_rank = expected_ranks.pop_front();
        if (out_data.rank !== want_rank.rank)
          report_mismatch("rank", 32'(out_data.rank), 32'(want_rank.rank));
        if (out_data.uniform_value !== want_rank.uniform_value)
          report_mismatch("uniform_value", 32'(out_data.uniform_value),
                          32'(want_rank.uniform_value));
        if (out_data.no_rank !== want_rank.no_rank)
          report_mismatch("no_rank", 32'(out_data.no_rank), 32'(want_rank.no_rank));
      end
      ranks_checked++;
      if (out_data.no_rank === 1'b1)
        misses_seen++;
      stall_left = recv_idle_en ? $urandom_range(13, 0) : 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d ranks outstanding", cycle_count,
               expected_ranks.size());
      $display("zipf_rank_sampler regression: fail");
      $finish;
    end
  end

  // every entry gets written before the first draw
  task automatic load_zipf_table();
    send_idle_en = 1'b0;
    for (int r = 1; r <= MAX_RANKS; r++)
      send(ACT_LOAD, r, zipf_weight(r));
    send_idle_en = 1'b1;
  endtask

  task automatic test_reset_state();
    repeat (3) send(ACT_DRAW, 0, '0);
    send(ACT_RESTART, 0, '0);
    send(ACT_DRAW, 0, '0);
  endtask

  task automatic test_corner_cases();
    write_reg(REG_N_ACTIVE, 31'd1);
    send(ACT_LOAD, 1, 31'd0);              // nothing reaches x
    send(ACT_DRAW, 0, '0);
    send(ACT_LOAD, 1, LCG_M);
    send(ACT_DRAW, 0, '0);
    write_reg(REG_N_ACTIVE, 31'd2);
    send(ACT_LOAD, 1, 31'h4000_0000);      // second add saturates
    send(ACT_LOAD, 2, LCG_M);
    repeat (3) send(ACT_DRAW, 0, '0);
    // out-of-range loads and the spare action leave the table alone
    send(ACT_LOAD, 0, 31'h5555_5555);
    send(ACT_LOAD, 2047, 31'd0);
    send(ACT_LOAD, 1025, 31'd0);
    send(ACT_UNUSED, 11'h7FF, LCG_M);
    send(ACT_LOAD, 1024, zipf_weight(1024));
    send(ACT_DRAW, 0, '0);
    write_reg(REG_SEED, 31'd0);            // locking seeds restart from 1
    send(ACT_RESTART, 0, '0);
    send(ACT_DRAW, 0, '0);
    write_reg(REG_SEED, LCG_M);
    send(ACT_RESTART, 0, '0);
    send(ACT_DRAW, 0, '0);
    write_reg(REG_SEED, SEED_TOP);
    send(ACT_RESTART, 0, '0);
    send(ACT_DRAW, 0, '0);
    write_reg(REG_N_ACTIVE, 31'd0);
    send(ACT_DRAW, 0, '0);
    write_reg(REG_N_ACTIVE, 31'd2047);
    send(ACT_DRAW, 0, '0);
    send(ACT_LOAD, 1, zipf_weight(1));
    send(ACT_LOAD, 2, zipf_weight(2));
  endtask

  // hold the result side long enough that the input backs up
  task automatic test_output_hold();
    write_reg(REG_N_ACTIVE, 31'd8);
    send_idle_en = 1'b0;
    hold_request = 400;
    repeat (24) send(ACT_DRAW, 0, '0);
    send_idle_en = 1'b1;
  endtask

  function automatic in_t random_item(input int n_eff);
    in_t it;
    int  pick;
    it.action = ACT_DRAW;
    it.rank_index = 11'($urandom);
    it.weight = 31'($urandom);
    pick = $urandom_range(99, 0);
    if (pick >= 96) begin
      it.action = ACT_UNUSED;
    end else if (pick >= 88) begin
      it.action = ACT_RESTART;
    end else if (pick >= 68) begin
      it.action = ACT_LOAD;
      pick = $urandom_range(99, 0);
      if (pick < 85)
        it.rank_index = 11'($urandom_range(n_eff, 1));
      else if (pick < 95)
        it.rank_index = 11'($urandom_range(MAX_RANKS, 1));
      else if (pick < 97)
        it.rank_index = 11'd0;
      else
        it.rank_index = 11'($urandom_range(2047, MAX_RANKS + 1));
      pick = $urandom_range(99, 0);
      if (pick < 50)
        it.weight = zipf_weight(it.rank_index == 11'd0 ? 1 : int'(it.rank_index));
      else if (pick < 65)
        it.weight = 31'd0;
      else if (pick < 75)
        it.weight = 31'($urandom_range(65535, 0));
    end
    return it;
  endfunction

  task automatic test_random_phases();
    int          random_items;
    int          n_eff;
    int          phase_items;
    logic [10:0] n_cfg;
    logic [30:0] seed_cfg;
    in_t         item;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(9, 0))
        0:       n_cfg = 11'($urandom_range(1, 0));
        1:       n_cfg = 11'($urandom_range(1023, 65));
        2:       n_cfg = ($urandom_range(1, 0) != 0) ? N_MAX : 11'($urandom_range(2047, 1025));
        default: n_cfg = 11'($urandom_range(64, 2));
      endcase
      case ($urandom_range(7, 0))
        0:       seed_cfg = 31'd0;
        1:       seed_cfg = LCG_M;
        2:       seed_cfg = ($urandom_range(1, 0) != 0) ? 31'd1 : SEED_TOP;
        default: seed_cfg = 31'($urandom_range(SEED_TOP, 1));
      endcase
      write_reg(REG_N_ACTIVE, 31'(n_cfg));
      write_reg(REG_SEED, seed_cfg);
      settings_used++;
      n_eff = active_ranks(n_cfg);
      send_idle_en = $urandom_range(3, 0) != 0;
      recv_idle_en = $urandom_range(3, 0) != 0;
      phase_items = (n_eff > 64) ? 8 : 40;
      send(ACT_RESTART, $urandom_range(2047, 0), 31'($urandom));
      random_items++;
      repeat (phase_items) begin
        item = random_item(n_eff);
        send_item(item);
        if (!is_ignored(item))
          random_items++;
      end
    end
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    load_zipf_table();
    test_reset_state();
    test_corner_cases();
    test_output_hold();
    test_random_phases();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    $display("Checked %0d ranks (%0d short of x) from %0d draws, %0d loads, %0d restarts",
             ranks_checked, misses_seen, draws_sent, loads_applied, restarts_sent);
    $display("Random phases used %0d n_active/seed settings; %0d mismatches",
             settings_used, mismatches);
    if (mismatches == 0)
      $display("zipf_rank_sampler regression: pass");
    else
      $display("zipf_rank_sampler regression: fail");
    $finish;
  end

endmodule
